@@ sv/apcc_pkg.sv @@
`default_nettype none

package apcc_pkg;

  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] ASSET_MAGIC   = 32'h4144_4854;
  localparam logic [31:0] ASSET_VERSION = 32'h0000_0001;

  localparam int unsigned OFFSET_W = 25;

  localparam logic [2:0] ST_PASS         = 3'd0;
  localparam logic [2:0] ST_NOT_READY    = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC    = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION  = 3'd3;
  localparam logic [2:0] ST_BAD_LENGTH   = 3'd4;
  localparam logic [2:0] ST_CRC_MISMATCH = 3'd5;
  localparam logic [2:0] ST_READ_ERROR   = 3'd6;

  localparam logic REG_DEVICE_READY    = 1'b0;
  localparam logic REG_MANIFEST_OFFSET = 1'b1;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_req;
    logic       read_error;
  } item_t;

endpackage

`default_nettype wire

@@ sv/apcc_crc8.sv @@
`default_nettype none

module apcc_crc8
  import apcc_pkg::*;
(
  input  wire logic [31:0] crc_i,
  input  wire logic [7:0]  data_i,
  output logic      [31:0] crc_o
);

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'b0, data_i};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

@@ sv/apcc_ctrl.sv @@
`default_nettype none

module apcc_ctrl
  import apcc_pkg::*;
#(
  parameter int unsigned MANIFEST_BYTES = 24,
  parameter int unsigned ADDRESS_BITS   = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                item_valid_i,
  input  wire item_t               item_i,
  output logic                     item_take_o,
  input  wire logic                device_ready_i,
  input  wire logic [OFFSET_W-1:0] manifest_offset_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [2:0]          status_o,
  output logic      [31:0]         computed_crc_o
);

  localparam int unsigned CntW = $clog2(MANIFEST_BYTES);
  localparam logic [CntW-1:0] LastIdx = CntW'(MANIFEST_BYTES - 1);
  localparam logic [32:0] AddrLimit = 33'(1) << ADDRESS_BITS;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_MANIFEST = 2'd1;
  localparam logic [1:0] PH_DATA     = 2'd2;

  logic [1:0]          phase_q, phase_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [31:0]         shift_q, shift_d;
  logic [31:0]         exp_q, exp_d;
  logic [31:0]         crc_q, crc_d;
  logic [OFFSET_W-1:0] rem_q, rem_d;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [31:0] res_crc_q;

  logic        res_valid;
  logic [2:0]  res_status;
  logic [31:0] res_crc;
  logic [31:0] crc_next;

  apcc_crc8 u_crc8 (
    .crc_i  (crc_q),
    .data_i (item_i.byte_value),
    .crc_o  (crc_next)
  );

  always_comb begin
    logic [1:0]      ph;
    logic [CntW-1:0] cnt;
    logic [31:0]     sh;
    logic [32:0]     bound;
    logic [31:0]     fin;

    phase_d    = phase_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    exp_d      = exp_q;
    crc_d      = crc_q;
    rem_d      = rem_q;
    res_valid  = 1'b0;
    res_status = ST_PASS;
    res_crc    = 32'b0;

    ph    = item_i.start_req ? PH_MANIFEST : phase_q;
    cnt   = item_i.start_req ? '0 : cnt_q;
    sh    = {item_i.byte_value, (item_i.start_req ? 24'b0 : shift_q[31:8])};
    bound = (AddrLimit > 33'(manifest_offset_i)) ? 33'(manifest_offset_i) : AddrLimit;
    fin   = ~crc_next;

    if (item_i.start_req) begin
      phase_d = PH_MANIFEST;
      cnt_d   = '0;
      shift_d = 32'b0;
    end

    if (item_i.start_req && !device_ready_i) begin
      res_valid  = 1'b1;
      res_status = ST_NOT_READY;
    end else if (ph == PH_MANIFEST) begin
      if (item_i.read_error) begin
        res_valid  = 1'b1;
        res_status = ST_READ_ERROR;
      end else begin
        shift_d = sh;
        if (cnt == CntW'(3) && sh != ASSET_MAGIC) begin
          res_valid  = 1'b1;
          res_status = ST_BAD_MAGIC;
        end else if (cnt == CntW'(7) && sh != ASSET_VERSION) begin
          res_valid  = 1'b1;
          res_status = ST_BAD_VERSION;
        end else if (cnt == CntW'(11) && (sh == 32'b0 || {1'b0, sh} > bound)) begin
          res_valid  = 1'b1;
          res_status = ST_BAD_LENGTH;
        end else begin
          if (cnt == CntW'(11)) begin
            rem_d = sh[OFFSET_W-1:0];
          end
          if (cnt == CntW'(15)) begin
            exp_d = sh;
          end
          if (cnt == LastIdx) begin
            phase_d = PH_DATA;
            crc_d   = CRC_ALL_ONES;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt + 1'b1;
          end
        end
      end
    end else if (ph == PH_DATA) begin
      if (item_i.read_error) begin
        res_valid  = 1'b1;
        res_status = ST_READ_ERROR;
      end else begin
        crc_d = crc_next;
        rem_d = rem_q - 1'b1;
        if (rem_q == OFFSET_W'(1)) begin
          res_valid  = 1'b1;
          res_status = (fin == exp_q) ? ST_PASS : ST_CRC_MISMATCH;
          res_crc    = fin;
        end
      end
    end

    if (res_valid) begin
      phase_d = PH_IDLE;
    end
  end

  assign item_take_o = item_valid_i && (!res_valid || !out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      shift_q <= 32'b0;
      exp_q   <= 32'b0;
      crc_q   <= CRC_ALL_ONES;
      rem_q   <= '0;
    end else if (item_take_o) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      exp_q   <= exp_d;
      crc_q   <= crc_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_take_o && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && res_valid) begin
      status_q  <= res_status;
      res_crc_q <= res_crc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign computed_crc_o = res_crc_q;

endmodule

`default_nettype wire

@@ sv/asset_package_crc_checker.sv @@
// Channel   Dir  Handshake              Payload
// in        in   in_valid_i/in_ready_o  byte_value_i, start_req_i, read_error_i
// out       out  out_valid_o/out_ready_i status_o, computed_crc_o
// cfg       in   cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One byte per cycle while in_ready_o is high: input register, one pass of
// compare and eight-step CRC byte update, then the result register.
// A result reaches out_valid_o through the input register, then the result register.
// Reset clears run state and config registers; no clearing pass.
// in_ready_o drops only when a verdict is due, the result register is full and out_ready_i is low.
`default_nettype none

module asset_package_crc_checker
  import apcc_pkg::*;
#(
  parameter int unsigned MANIFEST_BYTES = 24,
  parameter int unsigned ADDRESS_BITS   = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          byte_value_i,
  input  wire logic                start_req_i,
  input  wire logic                read_error_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [2:0]          status_o,
  output logic      [31:0]         computed_crc_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [OFFSET_W-1:0] cfg_wdata_i
);

  logic                in_valid_q;
  item_t               item_q;
  logic                take;
  logic                device_ready_q;
  logic [OFFSET_W-1:0] manifest_offset_q;

  assign in_ready_o = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.byte_value <= byte_value_i;
      item_q.start_req  <= start_req_i;
      item_q.read_error <= read_error_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_ready_q    <= 1'b0;
      manifest_offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DEVICE_READY:    device_ready_q    <= cfg_wdata_i[0];
        REG_MANIFEST_OFFSET: manifest_offset_q <= cfg_wdata_i;
        default:             ;
      endcase
    end
  end

  apcc_ctrl #(
    .MANIFEST_BYTES (MANIFEST_BYTES),
    .ADDRESS_BITS   (ADDRESS_BITS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (in_valid_q),
    .item_i            (item_q),
    .item_take_o       (take),
    .device_ready_i    (device_ready_q),
    .manifest_offset_i (manifest_offset_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .computed_crc_o    (computed_crc_o)
  );

`ifndef NO_ASSERTIONS
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_crc_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_PASS && status_o != ST_CRC_MISMATCH)
      |-> (computed_crc_o == 32'b0))
    else $error("nonzero crc on early verdict");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 3'd7))
    else $error("undefined status code");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(take))
    else $error("result without a consumed item");
`endif

endmodule

`default_nettype wire

@@ sim/asset_verdict_checker.sv @@
`timescale 1ns / 100ps

package image_crc_pkg;

  // Reflected CRC-32, one byte, LSB first.
  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    int k;
    c = crc ^ {24'h0, data};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ apcc_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module asset_verdict_checker
  import apcc_pkg::*;
  import image_crc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [7:0]          byte_value_i,
  input  logic                start_req_i,
  input  logic                read_error_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [2:0]          status_i,
  input  logic [31:0]         computed_crc_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [OFFSET_W-1:0] cfg_wdata_i,
  output int unsigned         error_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_bytes_o,
  output int unsigned         verdicts_o,
  output int unsigned         passes_o
);

  localparam int unsigned MANIFEST_LEN = 24;
  localparam logic [31:0] ADDR_SPAN    = 32'h0100_0000;
  localparam logic [4:0]  MAGIC_LAST   = 5'd3;
  localparam logic [4:0]  VERSION_LAST = 5'd7;
  localparam logic [4:0]  LENGTH_LAST  = 5'd11;
  localparam logic [4:0]  CRC_LAST     = 5'd15;

  typedef enum logic [1:0] {IMG_IDLE, IMG_MANIFEST, IMG_DATA} image_phase_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] crc;
  } verdict_t;

  verdict_t            expected_verdicts[$];
  image_phase_e        phase;
  logic [4:0]          manifest_pos;
  logic [31:0]         manifest_word;
  logic [31:0]         data_length;
  logic [31:0]         stored_crc;
  logic [31:0]         crc_acc;
  logic [OFFSET_W-1:0] bytes_left;
  logic                device_ready;
  logic [OFFSET_W-1:0] length_limit;

  task automatic post_verdict(input logic [2:0] status, input logic [31:0] crc);
    verdict_t v;
    v.status = status;
    v.crc    = crc;
    expected_verdicts.push_back(v);
    phase = IMG_IDLE;
  endtask

  task automatic predict_byte(input logic [7:0] value, input logic start, input logic rd_err);
    logic [31:0] bound;
    logic [31:0] final_crc;
    if (start) begin
      manifest_pos  = '0;
      manifest_word = '0;
      data_length   = '0;
      stored_crc    = '0;
      crc_acc       = CRC_ALL_ONES;
      bytes_left    = '0;
      if (!device_ready) begin
        post_verdict(ST_NOT_READY, '0);
        return;
      end
      phase = IMG_MANIFEST;
    end
    case (phase)
      IMG_MANIFEST: begin
        if (rd_err) begin
          post_verdict(ST_READ_ERROR, '0);
          return;
        end
        manifest_word = {value, manifest_word[31:8]};
        if (manifest_pos == MAGIC_LAST && manifest_word != ASSET_MAGIC) begin
          post_verdict(ST_BAD_MAGIC, '0);
          return;
        end
        if (manifest_pos == VERSION_LAST && manifest_word != ASSET_VERSION) begin
          post_verdict(ST_BAD_VERSION, '0);
          return;
        end
        if (manifest_pos == LENGTH_LAST) begin
          bound = ({7'd0, length_limit} < ADDR_SPAN) ? {7'd0, length_limit} : ADDR_SPAN;
          data_length = manifest_word;
          if (data_length == '0 || data_length > bound) begin
            post_verdict(ST_BAD_LENGTH, '0);
            return;
          end
        end
        if (manifest_pos == CRC_LAST) stored_crc = manifest_word;
        if (manifest_pos == MANIFEST_LEN - 1) begin
          phase        = IMG_DATA;
          crc_acc      = CRC_ALL_ONES;
          bytes_left   = data_length[OFFSET_W-1:0];
          manifest_pos = '0;
        end else begin
          manifest_pos++;
        end
      end
      IMG_DATA: begin
        if (rd_err) begin
          post_verdict(ST_READ_ERROR, '0);
          return;
        end
        crc_acc = crc32_step(crc_acc, value);
        if (bytes_left != '0) bytes_left--;
        if (bytes_left == '0) begin
          final_crc = ~crc_acc;
          post_verdict((final_crc == stored_crc) ? ST_PASS : ST_CRC_MISMATCH, final_crc);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      expected_verdicts.delete();
      phase           = IMG_IDLE;
      manifest_pos    = '0;
      manifest_word   = '0;
      data_length     = '0;
      stored_crc      = '0;
      crc_acc         = CRC_ALL_ONES;
      bytes_left      = '0;
      device_ready    = 1'b0;
      length_limit    = '0;
      error_count_o   = 0;
      pending_o       = 0;
      checked_bytes_o = 0;
      verdicts_o      = 0;
      passes_o        = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          error_count_o++;
          $display("%0t: unexpected verdict, actual status %0d crc %h",
                   $time, status_i, computed_crc_i);
        end else begin
          want = expected_verdicts.pop_front();
          if (status_i !== want.status) begin
            error_count_o++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
          end
          if (computed_crc_i !== want.crc) begin
            error_count_o++;
            $display("%0t: computed_crc expected %h actual %h", $time, want.crc, computed_crc_i);
          end
          verdicts_o++;
          if (want.status == ST_PASS) passes_o++;
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == REG_DEVICE_READY) device_ready = cfg_wdata_i[0];
        else length_limit = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        if (start_req_i || phase != IMG_IDLE) checked_bytes_o++;
        predict_byte(byte_value_i, start_req_i, read_error_i);
      end
      pending_o = expected_verdicts.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import apcc_pkg::*;
  import image_crc_pkg::*;

  localparam int unsigned         CLK_PERIOD       = 10;
  localparam int unsigned         RESET_CYCLES     = 7;
  localparam int unsigned         ITEM_TARGET      = 800;
  localparam int unsigned         RUNS_PER_SETTING = 10;
  localparam int unsigned         SETTLE_CYCLES    = 4;
  localparam int unsigned         WATCHDOG_LIMIT   = 2000;
  localparam int                  MANIFEST_LEN     = 24;
  localparam int                  FIELD_BYTES      = 16;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX       = 25'h100_0000;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, start_req_i = 1'b0, read_error_i = 1'b0, out_ready_i = 1'b0;
  logic [7:0] byte_value_i = 8'h00;
  logic cfg_we_i = 1'b0, cfg_index_i = REG_DEVICE_READY;
  logic [OFFSET_W-1:0] cfg_wdata_i = '0;
  logic in_ready_o, out_valid_o;
  logic [2:0] status_o;
  logic [31:0] computed_crc_o;

  int unsigned error_count, pending, checked_bytes, verdicts, passes;
  item_t stream_q[$];
  logic [OFFSET_W-1:0] cur_offset = '0;
  int unsigned burst_left = 0;
  int unsigned setting_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned phase_idx = 0;
  int unsigned sent_bytes = 0;
  int unsigned run_idx = 0;
  logic [9:0] stall_tick = '0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  asset_package_crc_checker dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .byte_value_i, .start_req_i, .read_error_i,
    .out_valid_o, .out_ready_i, .status_o, .computed_crc_o,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  asset_verdict_checker verdict_chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .byte_value_i, .start_req_i, .read_error_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .computed_crc_i(computed_crc_o),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .error_count_o(error_count), .pending_o(pending), .checked_bytes_o(checked_bytes),
    .verdicts_o(verdicts), .passes_o(passes)
  );

  // receiver backpressure, mode chosen by stall_tick[9:8]
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[9:8])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready_i <= (stall_tick[2:0] == 3'd0);
      default: out_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] value, input logic start, input logic rd_err);
    item_t it;
    it.byte_value = value;
    it.start_req  = start;
    it.read_error = rd_err;
    stream_q.push_back(it);
  endtask

  // Manifest plus data; err_pos marks a failed read, cut_len truncates (-1: none).
  task automatic queue_image(input logic [31:0] magic, input logic [31:0] version,
                             input logic [31:0] length, input logic crc_ok,
                             input int err_pos, input int cut_len);
    logic [7:0]  payload[$];
    logic [31:0] words[4];
    logic [31:0] crc;
    logic [7:0]  value;
    int          n, total, k;
    n = (length <= 64) ? int'(length) : int'($urandom_range(0, 8));
    crc = CRC_ALL_ONES;
    for (k = 0; k < n; k++) begin
      payload.push_back(8'($urandom));
      crc = crc32_step(crc, payload[k]);
    end
    crc = ~crc;
    words[0] = magic;
    words[1] = version;
    words[2] = length;
    words[3] = crc_ok ? crc : crc ^ (32'd1 << $urandom_range(0, 31));
    total = MANIFEST_LEN + n;
    if (cut_len >= 0 && cut_len < total) total = cut_len;
    for (k = 0; k < total; k++) begin
      if (k < FIELD_BYTES) value = words[k / 4][8 * (k % 4) +: 8];
      else if (k < MANIFEST_LEN) value = 8'($urandom);
      else value = payload[k - MANIFEST_LEN];
      push_byte(value, k == 0, k == err_pos);
    end
  endtask

  task automatic queue_noise(input int unsigned n);
    repeat (n) push_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_random_run();
    logic [31:0] bound, good_len, bad_len, word;
    int unsigned pick;
    bound = (cur_offset < OFFSET_MAX) ? 32'(cur_offset) : 32'(OFFSET_MAX);
    good_len = $urandom_range(1, (bound != 0 && bound < 40) ? bound : 40);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      queue_image(ASSET_MAGIC, ASSET_VERSION, good_len, $urandom_range(0, 7) != 0, -1, -1);
    end else if (pick < 62) begin
      word = $urandom_range(0, 1) ? ASSET_MAGIC ^ (32'd1 << $urandom_range(0, 31)) : $urandom;
      queue_image(word, ASSET_VERSION, good_len, 1'b1, -1, -1);
    end else if (pick < 68) begin
      word = $urandom_range(0, 1) ? ASSET_VERSION ^ (32'd1 << $urandom_range(0, 31)) : $urandom;
      queue_image(ASSET_MAGIC, word, good_len, 1'b1, -1, -1);
    end else if (pick < 76) begin
      case ($urandom_range(0, 3))
        0:       bad_len = '0;
        1:       bad_len = bound + 1;
        2:       bad_len = '1;
        default: bad_len = 32'(OFFSET_MAX) + 1;
      endcase
      queue_image(ASSET_MAGIC, ASSET_VERSION, bad_len, 1'b1, -1, -1);
    end else if (pick < 86) begin
      queue_image(ASSET_MAGIC, ASSET_VERSION, good_len, 1'b1,
                  $urandom_range(0, MANIFEST_LEN - 1 + good_len), -1);
    end else if (pick < 93) begin
      queue_image(ASSET_MAGIC, ASSET_VERSION, good_len, 1'b1, -1,
                  $urandom_range(1, MANIFEST_LEN - 1 + good_len));
    end else begin
      queue_noise($urandom_range(1, 6));
    end
  endtask

  // Sends bursts until only `keep` bytes are left queued.
  task automatic drive_stream(input int unsigned keep);
    item_t it;
    int unsigned gap;
    while (stream_q.size() > keep) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      it = stream_q.pop_front();
      in_valid_i   <= 1'b1;
      byte_value_i <= it.byte_value;
      start_req_i  <= it.start_req;
      read_error_i <= it.read_error;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      sent_bytes++;
      burst_left--;
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic ready, input logic [OFFSET_W-1:0] offset);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_DEVICE_READY;
    cfg_wdata_i <= {{(OFFSET_W - 1){1'b0}}, ready};
    @(posedge clk_i);
    cfg_index_i <= REG_MANIFEST_OFFSET;
    cfg_wdata_i <= offset;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_offset = offset;
    setting_count++;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // still not ready after reset: start fails, following byte ignored
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'h00, 1'b0, 1'b0);
    drive_stream(0);

    reconfigure(1'b1, 25'd5);
    queue_image(ASSET_MAGIC ^ 32'h8000_0000, ASSET_VERSION, 32'd5, 1'b1, -1, 4);
    queue_image(ASSET_MAGIC, 32'd0, 32'd5, 1'b1, -1, 8);
    queue_image(ASSET_MAGIC, ASSET_VERSION, 32'd0, 1'b1, -1, 12);
    queue_image(ASSET_MAGIC, ASSET_VERSION, 32'd6, 1'b1, -1, 12);
    queue_image(ASSET_MAGIC, ASSET_VERSION, 32'd5, 1'b0, -1, -1);
    queue_image(ASSET_MAGIC, ASSET_VERSION, 32'd5, 1'b1, MANIFEST_LEN + 4, -1);
    queue_image(ASSET_MAGIC, ASSET_VERSION, 32'd3, 1'b1, -1, 10);
    queue_image(ASSET_MAGIC, ASSET_VERSION, 32'd5, 1'b1, -1, -1);
    drive_stream(3);
    // ready dropped in the middle of a run: run still completes, next start fails
    reconfigure(1'b0, 25'd5);
    push_byte(8'h5A, 1'b1, 1'b0);
    drive_stream(0);

    reconfigure(1'b1, OFFSET_MAX);
    queue_image(ASSET_MAGIC, ASSET_VERSION, 32'h0100_0001, 1'b1, -1, 12);
    queue_image(ASSET_MAGIC, ASSET_VERSION, 32'd1, 1'b1, -1, -1);
    drive_stream(0);

    do begin
      case (phase_idx % 6)
        0:       reconfigure(1'b1, OFFSET_MAX);
        1:       reconfigure(1'b1, OFFSET_W'($urandom_range(1, 40)));
        2:       reconfigure(1'b0, OFFSET_W'($urandom_range(0, OFFSET_MAX)));
        3:       reconfigure(1'b1, OFFSET_W'($urandom_range(41, OFFSET_MAX)));
        4:       reconfigure(1'b1, '0);
        default: reconfigure(1'b1, OFFSET_W'($urandom_range(1, 40)));
      endcase
      run_idx = 0;
      while (run_idx < RUNS_PER_SETTING && sent_bytes + stream_q.size() < ITEM_TARGET) begin
        queue_random_run();
        run_idx++;
      end
      drive_stream(0);
      phase_idx++;
    end while (sent_bytes < ITEM_TARGET);

    wait_drained();
    $display("coverage: %0d bytes sent, %0d inside image checks, %0d verdicts, %0d passes",
             sent_bytes, checked_bytes, verdicts, passes);
    $display("coverage: %0d register settings applied", setting_count);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
